// File: design/ddwr_pkg.sv
// ----------------------------------------------------------------------------
// ddwr_pkg
// Shared types, widths, register codes and helpers for the wheel rate block.
// ----------------------------------------------------------------------------
`default_nettype none

package ddwr_pkg;

    // field widths
    localparam int VEL_W   = 32;
    localparam int RATE_W  = 32;
    localparam int TRACK_W = 24;
    localparam int DIAM_W  = 24;
    localparam int PPR_W   = 32;
    localparam int MAXR_W  = 32;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int QUO_W   = 64;

    // signed angular velocity times zero-extended track width
    localparam int TURN_W  = VEL_W + TRACK_W + 1;

    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_DEPTH       = 4;

    // register indexes
    localparam logic [IDX_W-1:0] REG_TRACK = 2'd0;
    localparam logic [IDX_W-1:0] REG_DIAM  = 2'd1;
    localparam logic [IDX_W-1:0] REG_PPR   = 2'd2;
    localparam logic [IDX_W-1:0] REG_MAXR  = 2'd3;

    // reset values
    localparam logic [TRACK_W-1:0] TRACK_RST = 24'd13107;
    localparam logic [DIAM_W-1:0]  DIAM_RST  = 24'd4588;
    localparam logic [PPR_W-1:0]   PPR_RST   = 32'd13107200;
    localparam logic [MAXR_W-1:0]  MAXR_RST  = 32'd65536000;

    typedef struct packed {
        logic [TRACK_W-1:0] track_width;
        logic [DIAM_W-1:0]  wheel_diam;
        logic [PPR_W-1:0]   pulses_per_rad;
        logic [MAXR_W-1:0]  max_rate;
    } t_cfg;

    // width of the signed wheel numerator 2*v*2^F -/+ w*track
    function automatic int num_w(int frac);
        int tw;
        tw = VEL_W + frac + 1;
        return ((tw > TURN_W) ? tw : TURN_W) + 1;
    endfunction

    // sign and clamp an unsigned magnitude into the signed output range
    function automatic logic [RATE_W-1:0] sat_rate(logic neg, logic [RATE_W-1:0] mag);
        logic [RATE_W-1:0] res;
        if (neg) begin
            res = mag[RATE_W-1] ? {1'b1, {(RATE_W-1){1'b0}}} : (~mag + RATE_W'(1));
        end else begin
            res = mag[RATE_W-1] ? {1'b0, {(RATE_W-1){1'b1}}} : mag;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/ddwr_cmd_if.sv
// ----------------------------------------------------------------------------
// ddwr_cmd_if
// Body velocity command channel: valid/ready with linear and angular velocity.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddwr_cmd_if;
    logic                             valid;
    logic                             ready;
    logic signed [ddwr_pkg::VEL_W-1:0] linear_vel;
    logic signed [ddwr_pkg::VEL_W-1:0] angular_vel;

    modport source (output valid, output linear_vel, output angular_vel, input ready);
    modport sink   (input valid, input linear_vel, input angular_vel, output ready);
endinterface

`default_nettype wire

// File: design/ddwr_rate_if.sv
// ----------------------------------------------------------------------------
// ddwr_rate_if
// Wheel rate result channel: valid/ready with left/right rates and scale flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddwr_rate_if;
    logic                              valid;
    logic                              ready;
    logic signed [ddwr_pkg::RATE_W-1:0] left_rate;
    logic signed [ddwr_pkg::RATE_W-1:0] right_rate;
    logic                              was_scaled;

    modport source (output valid, output left_rate, output right_rate,
                    output was_scaled, input ready);
    modport sink   (input valid, input left_rate, input right_rate,
                    input was_scaled, output ready);
endinterface

`default_nettype wire

// File: design/diff_drive_wheel_rates.sv
// ----------------------------------------------------------------------------
// diff_drive_wheel_rates
// Differential drive inverse kinematics: body velocity command to left and
// right wheel pulse rates, limited to a maximum rate with ratio kept.
//
//   channel   | dir | handshake    | payload
//   ----------+-----+--------------+---------------------------------------
//   i_cmd     | in  | valid/ready  | linear_vel, angular_vel (s32 Q)
//   o_rate    | out | valid/ready  | left_rate, right_rate (s32 Q), was_scaled
//   i_cfg_*   | in  | write enable | i_cfg_idx, i_cfg_data
//
// One command per cycle, sustained while the output is not stalled. The two
// bit-per-stage dividers take 64 stages by diameter and 32 stages for the limit.
// Synchronous active-low reset clears valid flags and the registers to defaults.
// A stalled output freezes the back pipeline; a 4-entry queue and the front
// register keep taking commands until they fill.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_wheel_rates #(
    parameter int FRAC_BITS = ddwr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ddwr_pkg::IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ddwr_pkg::CFG_W-1:0]  i_cfg_data,
    ddwr_cmd_if.sink                         i_cmd,
    ddwr_rate_if.source                      o_rate
);

    localparam int EW = 2 * ddwr_pkg::num_w(FRAC_BITS) + 2;

    ddwr_pkg::t_cfg r_cfg;
    logic           w_push, w_can_push, w_q_valid, w_pop;
    logic [EW-1:0]  w_push_data, w_q_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.track_width    <= ddwr_pkg::TRACK_RST;
            r_cfg.wheel_diam     <= ddwr_pkg::DIAM_RST;
            r_cfg.pulses_per_rad <= ddwr_pkg::PPR_RST;
            r_cfg.max_rate       <= ddwr_pkg::MAXR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ddwr_pkg::REG_TRACK: r_cfg.track_width <= i_cfg_data[ddwr_pkg::TRACK_W-1:0];
                ddwr_pkg::REG_DIAM:  r_cfg.wheel_diam  <= i_cfg_data[ddwr_pkg::DIAM_W-1:0];
                ddwr_pkg::REG_PPR:   r_cfg.pulses_per_rad <= i_cfg_data[ddwr_pkg::PPR_W-1:0];
                ddwr_pkg::REG_MAXR:  r_cfg.max_rate    <= i_cfg_data[ddwr_pkg::MAXR_W-1:0];
                default: ;
            endcase
        end
    end

    ddwr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_track    (r_cfg.track_width),
        .i_cmd      (i_cmd),
        .o_push     (w_push),
        .o_data     (w_push_data),
        .i_can_push (w_can_push)
    );

    ddwr_queue #(.W(EW), .DEPTH(ddwr_pkg::Q_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_data     (w_push_data),
        .o_can_push (w_can_push),
        .o_valid    (w_q_valid),
        .o_data     (w_q_data),
        .i_pop      (w_pop)
    );

    ddwr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_pop),
        .o_rate    (o_rate)
    );

endmodule

`default_nettype wire

// File: design/ddwr_queue.sv
// ----------------------------------------------------------------------------
// ddwr_queue
// Small register FIFO between the command front end and the rate back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwr_queue #(
    parameter int W     = 8,
    parameter int DEPTH = ddwr_pkg::Q_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_can_push,
    output logic              o_valid,
    output logic [W-1:0]      o_data,
    input  wire logic         i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          w_push, w_pop;

    assign o_can_push = (r_count != CW'(DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_data     = r_mem[r_rd];
    assign w_push     = i_push && o_can_push;
    assign w_pop      = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill count above depth");

    // the back end only pops when an entry is present
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

    // a lone push grows the count by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not follow push");

endmodule

`default_nettype wire

// File: design/ddwr_divpipe.sv
// ----------------------------------------------------------------------------
// ddwr_divpipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwr_divpipe #(
    parameter int DW  = 40,
    parameter int NQ  = 64,
    parameter int PLW = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire logic [DW-1:0]  i_rem,
    input  wire logic [NQ-1:0]  i_low,
    input  wire logic [DW-1:0]  i_div,
    input  wire logic [PLW-1:0] i_pl,
    output logic                o_valid,
    output logic [NQ-1:0]       o_quo,
    output logic [PLW-1:0]      o_pl
);

    logic           r_v   [NQ];
    logic [DW-1:0]  r_rem [NQ];
    logic [NQ-1:0]  r_low [NQ];
    logic [NQ-1:0]  r_quo [NQ];
    logic [DW-1:0]  r_dv  [NQ];
    logic [PLW-1:0] r_pl  [NQ];

    for (genvar k = 0; k < NQ; k++) begin : g_stage
        logic           pv;
        logic [DW-1:0]  prem;
        logic [NQ-1:0]  plow;
        logic [NQ-1:0]  pquo;
        logic [DW-1:0]  pdv;
        logic [PLW-1:0] ppl;
        logic [DW:0]    rs;
        logic           ge;

        if (k == 0) begin : g_first
            assign pv   = i_valid;
            assign prem = i_rem;
            assign plow = i_low;
            assign pquo = '0;
            assign pdv  = i_div;
            assign ppl  = i_pl;
        end else begin : g_next
            assign pv   = r_v[k-1];
            assign prem = r_rem[k-1];
            assign plow = r_low[k-1];
            assign pquo = r_quo[k-1];
            assign pdv  = r_dv[k-1];
            assign ppl  = r_pl[k-1];
        end

        // shift in next dividend bit, trial subtract
        assign rs = {prem, plow[NQ-1]};
        assign ge = (rs >= {1'b0, pdv});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? DW'(rs - {1'b0, pdv}) : rs[DW-1:0];
                r_low[k] <= {plow[NQ-2:0], 1'b0};
                r_quo[k] <= {pquo[NQ-2:0], ge};
                r_dv[k]  <= pdv;
                r_pl[k]  <= ppl;
            end
        end
    end

    assign o_valid = r_v[NQ-1];
    assign o_quo   = r_quo[NQ-1];
    assign o_pl    = r_pl[NQ-1];

endmodule

`default_nettype wire

// File: design/ddwr_front.sv
// ----------------------------------------------------------------------------
// ddwr_front
// Accepts velocity commands, forms both wheel numerators, splits sign and
// magnitude, and pushes them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwr_front #(
    parameter int FRAC_BITS = ddwr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [ddwr_pkg::TRACK_W-1:0]  i_track,
    ddwr_cmd_if.sink                           i_cmd,
    output logic                               o_push,
    output logic [2*ddwr_pkg::num_w(FRAC_BITS)+1:0] o_data,
    input  wire logic                          i_can_push
);

    localparam int NW = ddwr_pkg::num_w(FRAC_BITS);

    logic                               r_a_v;
    logic signed [NW-1:0]               r_twice;
    logic signed [NW-1:0]               r_turn;
    logic                               w_ready;
    logic signed [NW-1:0]               w_twice;
    logic signed [ddwr_pkg::TURN_W-1:0] w_turn;
    logic signed [NW-1:0]               w_nl, w_nr;
    logic [NW-1:0]                      w_ml, w_mr;

    assign w_ready     = !r_a_v || i_can_push;
    assign i_cmd.ready = w_ready;

    // 2*v scaled to the numerator format, and w*track
    assign w_twice = NW'(i_cmd.linear_vel) <<< (FRAC_BITS + 1);
    assign w_turn  = i_cmd.angular_vel * $signed({1'b0, i_track});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (w_ready) begin
            r_a_v <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_cmd.valid) begin
            r_twice <= w_twice;
            r_turn  <= NW'(w_turn);
        end
    end

    // left and right numerators as sign plus magnitude
    assign w_nl = r_twice - r_turn;
    assign w_nr = r_twice + r_turn;
    assign w_ml = w_nl[NW-1] ? NW'(-w_nl) : NW'(w_nl);
    assign w_mr = w_nr[NW-1] ? NW'(-w_nr) : NW'(w_nr);

    assign o_push = r_a_v && i_can_push;
    assign o_data = {w_nl[NW-1], w_nr[NW-1], w_ml, w_mr};

endmodule

`default_nettype wire

// File: design/ddwr_back.sv
// ----------------------------------------------------------------------------
// ddwr_back
// Turns numerator magnitudes into wheel pulse rates: multiply by pulses per
// radian, divide by diameter, limit to the maximum rate, saturate, output.
// ----------------------------------------------------------------------------
`default_nettype none

module ddwr_back #(
    parameter int FRAC_BITS = ddwr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ddwr_pkg::t_cfg                i_cfg,
    input  wire logic                          i_q_valid,
    input  wire logic [2*ddwr_pkg::num_w(FRAC_BITS)+1:0] i_q_data,
    output logic                               o_q_pop,
    ddwr_rate_if.source                        o_rate
);

    localparam int MW  = ddwr_pkg::num_w(FRAC_BITS);
    localparam int EW  = 2 * MW + 2;
    localparam int ML  = MW / 2;
    localparam int MH  = MW - ML;
    localparam int PPW = ddwr_pkg::PPR_W;
    localparam int PW  = MW + PPW;
    localparam int DW  = ddwr_pkg::DIAM_W + FRAC_BITS;
    localparam int QW  = ddwr_pkg::QUO_W;
    localparam int RW  = ddwr_pkg::RATE_W;
    localparam int XW  = ddwr_pkg::MAXR_W;
    localparam int HW  = QW / 2;
    localparam int SW  = QW + XW;

    logic w_en;

    // queue head unpack
    logic          w_negl, w_negr;
    logic [MW-1:0] w_ml, w_mr;

    // stage 1: partial products of magnitude times pulses per radian
    logic              r_s1_v;
    logic              r_s1_negl, r_s1_negr;
    logic [ML+PPW-1:0] r_s1_pl_lo, r_s1_pr_lo;
    logic [MH+PPW-1:0] r_s1_pl_hi, r_s1_pr_hi;

    // stage 2: full products
    logic          r_s2_v;
    logic          r_s2_negl, r_s2_negr;
    logic [PW-1:0] r_s2_p_l, r_s2_p_r;

    // first divide
    logic [ddwr_pkg::DIAM_W-1:0] w_diam_nz;
    logic [DW-1:0]               w_div1;
    logic [DW-1:0]               w_hi_l, w_hi_r;
    logic                        w_cap_l, w_cap_r;
    logic                        w_d1_v, w_d1_vr;
    logic [QW-1:0]               w_d1_ql, w_d1_qr;
    logic [1:0]                  w_d1_pll, w_d1_plr;

    // stage 3: capped rates
    logic          r_s3_v;
    logic          r_s3_negl, r_s3_negr;
    logic [QW-1:0] r_s3_rl, r_s3_rr;

    // stage 4: larger rate, limit check, scale partials
    logic             w_big_sel;
    logic [QW-1:0]    w_big;
    logic             r_s4_v;
    logic             r_s4_negl, r_s4_negr, r_s4_scaled;
    logic [QW-1:0]    r_s4_big;
    logic [RW-1:0]    r_s4_rl, r_s4_rr;
    logic [HW+XW-1:0] r_s4_l_lo, r_s4_l_hi, r_s4_r_lo, r_s4_r_hi;

    // stage 5: scale products
    logic          r_s5_v;
    logic          r_s5_negl, r_s5_negr, r_s5_scaled;
    logic [QW-1:0] r_s5_big;
    logic [RW-1:0] r_s5_rl, r_s5_rr;
    logic [SW-1:0] r_s5_pl, r_s5_pr;

    // second divide
    logic          w_d2_v, w_d2_vr;
    logic [XW-1:0] w_d2_ql, w_d2_qr;
    logic [RW+1:0] w_d2_pll;
    logic [RW:0]   w_d2_plr;
    logic          w_scaled;
    logic [RW-1:0] w_mag_l, w_mag_r;

    // output register
    logic          r_out_v;
    logic [RW-1:0] r_out_l, r_out_r;
    logic          r_out_sc;

    // whole back end moves unless a result is waiting
    assign w_en    = !r_out_v || o_rate.ready;
    assign o_q_pop = w_en && i_q_valid;

    assign w_negl = i_q_data[EW-1];
    assign w_negr = i_q_data[EW-2];
    assign w_ml   = i_q_data[2*MW-1:MW];
    assign w_mr   = i_q_data[MW-1:0];

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_negl  <= w_negl;
            r_s1_negr  <= w_negr;
            r_s1_pl_lo <= (ML+PPW)'(w_ml[ML-1:0]) * (ML+PPW)'(i_cfg.pulses_per_rad);
            r_s1_pl_hi <= (MH+PPW)'(w_ml[MW-1:ML]) * (MH+PPW)'(i_cfg.pulses_per_rad);
            r_s1_pr_lo <= (ML+PPW)'(w_mr[ML-1:0]) * (ML+PPW)'(i_cfg.pulses_per_rad);
            r_s1_pr_hi <= (MH+PPW)'(w_mr[MW-1:ML]) * (MH+PPW)'(i_cfg.pulses_per_rad);
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_negl <= r_s1_negl;
            r_s2_negr <= r_s1_negr;
            r_s2_p_l  <= (PW'(r_s1_pl_hi) << ML) + PW'(r_s1_pl_lo);
            r_s2_p_r  <= (PW'(r_s1_pr_hi) << ML) + PW'(r_s1_pr_lo);
        end
    end

    // divisor is the diameter in the product format; zero counts as one
    assign w_diam_nz = (i_cfg.wheel_diam == '0) ? ddwr_pkg::DIAM_W'(1) : i_cfg.wheel_diam;
    assign w_div1    = DW'(w_diam_nz) << FRAC_BITS;
    assign w_hi_l    = DW'(r_s2_p_l[PW-1:QW]);
    assign w_hi_r    = DW'(r_s2_p_r[PW-1:QW]);
    assign w_cap_l   = (w_hi_l >= w_div1);
    assign w_cap_r   = (w_hi_r >= w_div1);

    ddwr_divpipe #(.DW(DW), .NQ(QW), .PLW(2)) u_div1_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_v),
        .i_rem   (w_hi_l),
        .i_low   (r_s2_p_l[QW-1:0]),
        .i_div   (w_div1),
        .i_pl    ({r_s2_negl, w_cap_l}),
        .o_valid (w_d1_v),
        .o_quo   (w_d1_ql),
        .o_pl    (w_d1_pll)
    );

    ddwr_divpipe #(.DW(DW), .NQ(QW), .PLW(2)) u_div1_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_v),
        .i_rem   (w_hi_r),
        .i_low   (r_s2_p_r[QW-1:0]),
        .i_div   (w_div1),
        .i_pl    ({r_s2_negr, w_cap_r}),
        .o_valid (w_d1_vr),
        .o_quo   (w_d1_qr),
        .o_pl    (w_d1_plr)
    );

    // stage 3: overflowing quotient caps at all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (w_en) begin
            r_s3_v <= w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_negl <= w_d1_pll[1];
            r_s3_negr <= w_d1_plr[1];
            r_s3_rl   <= w_d1_pll[0] ? '1 : w_d1_ql;
            r_s3_rr   <= w_d1_plr[0] ? '1 : w_d1_qr;
        end
    end

    // stage 4
    assign w_big_sel = (r_s3_rl > r_s3_rr);
    assign w_big     = w_big_sel ? r_s3_rl : r_s3_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (w_en) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_negl   <= r_s3_negl;
            r_s4_negr   <= r_s3_negr;
            r_s4_big    <= w_big;
            r_s4_scaled <= (w_big > QW'(i_cfg.max_rate));
            r_s4_rl     <= r_s3_rl[RW-1:0];
            r_s4_rr     <= r_s3_rr[RW-1:0];
            r_s4_l_lo   <= (HW+XW)'(r_s3_rl[HW-1:0]) * (HW+XW)'(i_cfg.max_rate);
            r_s4_l_hi   <= (HW+XW)'(r_s3_rl[QW-1:HW]) * (HW+XW)'(i_cfg.max_rate);
            r_s4_r_lo   <= (HW+XW)'(r_s3_rr[HW-1:0]) * (HW+XW)'(i_cfg.max_rate);
            r_s4_r_hi   <= (HW+XW)'(r_s3_rr[QW-1:HW]) * (HW+XW)'(i_cfg.max_rate);
        end
    end

    // stage 5
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (w_en) begin
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_negl   <= r_s4_negl;
            r_s5_negr   <= r_s4_negr;
            r_s5_scaled <= r_s4_scaled;
            r_s5_big    <= r_s4_big;
            r_s5_rl     <= r_s4_rl;
            r_s5_rr     <= r_s4_rr;
            r_s5_pl     <= (SW'(r_s4_l_hi) << HW) + SW'(r_s4_l_lo);
            r_s5_pr     <= (SW'(r_s4_r_hi) << HW) + SW'(r_s4_r_lo);
        end
    end

    // rate * max / larger rate; quotient never exceeds max
    ddwr_divpipe #(.DW(QW), .NQ(XW), .PLW(RW+2)) u_div2_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s5_v),
        .i_rem   (r_s5_pl[SW-1:XW]),
        .i_low   (r_s5_pl[XW-1:0]),
        .i_div   (r_s5_big),
        .i_pl    ({r_s5_negl, r_s5_scaled, r_s5_rl}),
        .o_valid (w_d2_v),
        .o_quo   (w_d2_ql),
        .o_pl    (w_d2_pll)
    );

    ddwr_divpipe #(.DW(QW), .NQ(XW), .PLW(RW+1)) u_div2_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s5_v),
        .i_rem   (r_s5_pr[SW-1:XW]),
        .i_low   (r_s5_pr[XW-1:0]),
        .i_div   (r_s5_big),
        .i_pl    ({r_s5_negr, r_s5_rr}),
        .o_valid (w_d2_vr),
        .o_quo   (w_d2_qr),
        .o_pl    (w_d2_plr)
    );

    // pick scaled or plain magnitude
    assign w_scaled = w_d2_pll[RW];
    assign w_mag_l  = w_scaled ? RW'(w_d2_ql) : w_d2_pll[RW-1:0];
    assign w_mag_r  = w_scaled ? RW'(w_d2_qr) : w_d2_plr[RW-1:0];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_l  <= ddwr_pkg::sat_rate(w_d2_pll[RW+1], w_mag_l);
            r_out_r  <= ddwr_pkg::sat_rate(w_d2_plr[RW], w_mag_r);
            r_out_sc <= w_scaled;
        end
    end

    assign o_rate.valid      = r_out_v;
    assign o_rate.left_rate  = r_out_l;
    assign o_rate.right_rate = r_out_r;
    assign o_rate.was_scaled = r_out_sc;

    // scaled magnitudes never exceed the limit
    a_scaled_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d2_v && w_scaled) |-> (w_d2_ql <= i_cfg.max_rate && w_d2_qr <= i_cfg.max_rate))
        else $error("scaled rate above max_rate");

    // both wheel lanes stay in step
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_d1_v == w_d1_vr) && (w_d2_v == w_d2_vr))
        else $error("wheel lanes out of step");

endmodule

`default_nettype wire
